/* rtl/core/rotation_matrix_to_quaternion_top_assert.svh */
// Assertion macros used by the checker file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmq assertion failed");

// Next-cycle implication, disabled during reset.
`define RMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmq assertion failed");

// Next-cycle implication that is also checked across reset.
`define RMQ_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rmq assertion failed");

`endif

/* rtl/core/rmq_pkg.sv */
package rmq_pkg;

  typedef enum logic [1:0] {
    AXIS_W = 2'd0,
    AXIS_X = 2'd1,
    AXIS_Y = 2'd2,
    AXIS_Z = 2'd3
  } axis_t;

endpackage

/* rtl/core/rmq_ifaces.sv */
interface rmq_mat_if #(parameter int WORD_BITS = 16);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface rmq_quat_if #(parameter int WORD_BITS = 16);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] qx, qy, qz, qw;
  logic [1:0]                  largest_axis;
  logic                        degenerate;

  modport source (output valid, qx, qy, qz, qw, largest_axis, degenerate,
                  input ready);
  modport sink (input valid, qx, qy, qz, qw, largest_axis, degenerate,
                output ready);
endinterface

// Internal transaction between pipeline sections: the three numerators of the
// non-chosen components plus one unsigned magnitude (radicand or root).
interface rmq_work_if #(parameter int NUMW = 17, parameter int MAGW = 18);
  logic                   valid;
  logic                   ready;
  rmq_pkg::axis_t         axis;
  logic                   degen;
  logic signed [NUMW-1:0] n0, n1, n2;
  logic [MAGW-1:0]        mag;

  modport source (output valid, axis, degen, n0, n1, n2, mag, input ready);
  modport sink (input valid, axis, degen, n0, n1, n2, mag, output ready);
endinterface

/* rtl/core/rmq_select.sv */
module rmq_select #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 14
) (
  input logic      clk,
  input logic      rst,
  rmq_mat_if.sink  src,
  rmq_work_if.source dst
);
  import rmq_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int VW   = W + 2;
  localparam int NW   = W + 1;
  localparam int RADW = ((VW > F + 2) ? VW : F + 2) + 1;
  localparam logic signed [RADW-1:0] ONE = RADW'(1) << F;

  // Stage A: diagonal sums and off-diagonal pairs.
  logic                 va;
  logic signed [VW-1:0] vw, vx, vy, vz;
  logic signed [NW-1:0] pa, pb, pc, pe, pf, pg;

  // Stage B: selection and radicand.
  logic                   vb;
  axis_t                  axis;
  logic                   degen;
  logic signed [NW-1:0]   n0, n1, n2;
  logic [RADW-2:0]        mag;

  logic                   rdy_a, rdy_b;
  logic signed [VW-1:0]   best_next;
  axis_t                  axis_next;
  logic signed [RADW-1:0] rad_next;
  logic                   degen_next;

  assign rdy_b     = !vb || dst.ready;
  assign rdy_a     = !va || rdy_b;
  assign src.ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (rdy_a) va <= src.valid;
      if (rdy_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && src.valid) begin
      vw <= VW'(src.m00) + VW'(src.m11) + VW'(src.m22);
      vx <= VW'(src.m00) - VW'(src.m11) - VW'(src.m22);
      vy <= VW'(src.m11) - VW'(src.m00) - VW'(src.m22);
      vz <= VW'(src.m22) - VW'(src.m00) - VW'(src.m11);
      pa <= NW'(src.m12) - NW'(src.m21);
      pb <= NW'(src.m20) - NW'(src.m02);
      pc <= NW'(src.m01) - NW'(src.m10);
      pe <= NW'(src.m01) + NW'(src.m10);
      pf <= NW'(src.m20) + NW'(src.m02);
      pg <= NW'(src.m12) + NW'(src.m21);
    end
  end

  // Strict comparisons: ties keep the earlier component.
  always_comb begin
    best_next = vw;
    axis_next = AXIS_W;
    if (vx > best_next) begin
      best_next = vx;
      axis_next = AXIS_X;
    end
    if (vy > best_next) begin
      best_next = vy;
      axis_next = AXIS_Y;
    end
    if (vz > best_next) begin
      best_next = vz;
      axis_next = AXIS_Z;
    end
    rad_next   = RADW'(best_next) + ONE;
    degen_next = rad_next[RADW-1] || (rad_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va) begin
      axis  <= axis_next;
      degen <= degen_next;
      mag   <= degen_next ? '0 : rad_next[RADW-2:0];
      case (axis_next)
        AXIS_W: begin
          n0 <= pa; n1 <= pb; n2 <= pc;
        end
        AXIS_X: begin
          n0 <= pe; n1 <= pf; n2 <= pa;
        end
        AXIS_Y: begin
          n0 <= pe; n1 <= pg; n2 <= pb;
        end
        AXIS_Z: begin
          n0 <= pf; n1 <= pg; n2 <= pc;
        end
        default: begin
          n0 <= pa; n1 <= pb; n2 <= pc;
        end
      endcase
    end
  end

  assign dst.valid = vb;
  assign dst.axis  = axis;
  assign dst.degen = degen;
  assign dst.n0    = n0;
  assign dst.n1    = n1;
  assign dst.n2    = n2;
  assign dst.mag   = mag;

endmodule

/* rtl/core/rmq_sqrt.sv */
module rmq_sqrt #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 14
) (
  input logic        clk,
  input logic        rst,
  rmq_work_if.sink   src,
  rmq_work_if.source dst
);
  import rmq_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int NW   = W + 1;
  localparam int RADW = ((W + 2 > F + 2) ? W + 2 : F + 2) + 1;
  localparam int SQW  = RADW - 1 + F;
  localparam int SQB  = (SQW + 1) / 2;
  localparam int SQW2 = 2 * SQB;
  localparam int REMW = SQB + 2;

  typedef struct packed {
    logic [REMW-1:0]      rem;
    logic [SQB-1:0]       root;
    logic [SQW2-1:0]      xs;
    axis_t                axis;
    logic                 degen;
    logic signed [NW-1:0] n0;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
  } sq_t;

  sq_t            init;
  sq_t            st  [SQB];
  sq_t            nx  [SQB];
  logic [SQB-1:0] v;
  logic [SQB:0]   rdy;

  always_comb begin
    init       = '0;
    init.xs    = SQW2'(src.mag) << F;
    init.axis  = src.axis;
    init.degen = src.degen;
    init.n0    = src.n0;
    init.n1    = src.n1;
    init.n2    = src.n2;
  end

  assign rdy[SQB]  = dst.ready;
  assign src.ready = rdy[0];

  // One root bit per stage: bring down two radicand bits, try (root*4+1).
  for (genvar i = 0; i < SQB; i++) begin : g_stage
    sq_t             p;
    logic            vin;
    logic [REMW-1:0] sh, tr;

    if (i == 0) begin : g_first
      assign p   = init;
      assign vin = src.valid;
    end else begin : g_rest
      assign p   = st[i-1];
      assign vin = v[i-1];
    end

    assign rdy[i] = !v[i] || rdy[i+1];

    always_comb begin
      sh    = {p.rem[REMW-3:0], p.xs[SQW2-1 -: 2]};
      tr    = {p.root, 2'b01};
      nx[i] = p;
      nx[i].xs = p.xs << 2;
      if (sh >= tr) begin
        nx[i].rem  = sh - tr;
        nx[i].root = {p.root[SQB-2:0], 1'b1};
      end else begin
        nx[i].rem  = sh;
        nx[i].root = {p.root[SQB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && vin) st[i] <= nx[i];
    end
  end

  assign dst.valid = v[SQB-1];
  assign dst.axis  = st[SQB-1].axis;
  assign dst.degen = st[SQB-1].degen;
  assign dst.n0    = st[SQB-1].n0;
  assign dst.n1    = st[SQB-1].n1;
  assign dst.n2    = st[SQB-1].n2;
  assign dst.mag   = st[SQB-1].root[SQB-1:1];

endmodule

/* rtl/core/rmq_div.sv */
module rmq_div #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 14
) (
  input logic        clk,
  input logic        rst,
  rmq_work_if.sink   src,
  rmq_quat_if.source dst
);
  import rmq_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int NW   = W + 1;
  localparam int RADW = ((W + 2 > F + 2) ? W + 2 : F + 2) + 1;
  localparam int SQW  = RADW - 1 + F;
  localparam int SQB  = (SQW + 1) / 2;
  localparam int BW   = SQB - 1;
  localparam int DW   = BW + 2;
  localparam int QW   = NW + F;
  localparam logic [63:0]   WMAX64 = (64'd1 << (W - 1)) - 64'd1;
  localparam logic [QW-1:0] QMAX   = QW'(WMAX64);
  localparam logic [QW-1:0] QMINM  = QW'(WMAX64 + 64'd1);
  localparam logic signed [W-1:0] SMAX = W'(WMAX64);
  localparam logic signed [W-1:0] SMIN = ~SMAX;

  typedef struct packed {
    logic [QW-1:0] dq;
    logic [DW-1:0] rem;
    logic          neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]   ln;
    logic [BW-1:0] big;
    axis_t         axis;
    logic          degen;
  } dv_t;

  dv_t           init;
  dv_t           st [QW];
  dv_t           nx [QW];
  logic [QW-1:0] v;
  logic [QW:0]   rdy;

  logic                 ov;
  logic signed [W-1:0]  qx, qy, qz, qw;
  axis_t                axis;
  logic                 degen;

  function automatic logic [NW-1:0] abs_num(input logic signed [NW-1:0] n);
    logic [NW-1:0] r;
    r = n[NW-1] ? NW'(-n) : NW'(n);
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0]       t;
    logic signed [W-1:0] r;
    t = ~q + QW'(1);
    if (neg) r = (q > QMINM) ? SMIN : t[W-1:0];
    else     r = (q > QMAX) ? SMAX : q[W-1:0];
    return r;
  endfunction

  always_comb begin
    init          = '0;
    init.big      = src.mag;
    init.axis     = src.axis;
    init.degen    = src.degen;
    init.ln[0].dq = {abs_num(src.n0), {F{1'b0}}};
    init.ln[1].dq = {abs_num(src.n1), {F{1'b0}}};
    init.ln[2].dq = {abs_num(src.n2), {F{1'b0}}};
    init.ln[0].neg = src.n0[NW-1];
    init.ln[1].neg = src.n1[NW-1];
    init.ln[2].neg = src.n2[NW-1];
  end

  assign rdy[QW]   = !ov || dst.ready;
  assign src.ready = rdy[0];

  // Restoring division, one quotient bit per stage in each of three lanes;
  // the divisor is four times the root.
  for (genvar i = 0; i < QW; i++) begin : g_stage
    dv_t          p;
    logic         vin;
    logic [DW:0]  dvs;

    if (i == 0) begin : g_first
      assign p   = init;
      assign vin = src.valid;
    end else begin : g_rest
      assign p   = st[i-1];
      assign vin = v[i-1];
    end

    assign rdy[i] = !v[i] || rdy[i+1];
    assign dvs    = {1'b0, p.big, 2'b00};

    always_comb begin
      logic [DW:0] sh;
      nx[i] = p;
      for (int k = 0; k < 3; k++) begin
        sh = {p.ln[k].rem, p.ln[k].dq[QW-1]};
        if (sh >= dvs) begin
          nx[i].ln[k].rem = DW'(sh - dvs);
          nx[i].ln[k].dq  = {p.ln[k].dq[QW-2:0], 1'b1};
        end else begin
          nx[i].ln[k].rem = sh[DW-1:0];
          nx[i].ln[k].dq  = {p.ln[k].dq[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && vin) st[i] <= nx[i];
    end
  end

  // Output register: saturate and place the components.
  dv_t                 last;
  logic signed [W-1:0] c0, c1, c2, bv;

  assign last = st[QW-1];
  assign c0   = sat(last.ln[0].dq, last.ln[0].neg);
  assign c1   = sat(last.ln[1].dq, last.ln[1].neg);
  assign c2   = sat(last.ln[2].dq, last.ln[2].neg);
  assign bv   = (64'(last.big) > WMAX64) ? SMAX : W'(last.big);

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (rdy[QW]) begin
      ov <= v[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[QW] && v[QW-1]) begin
      axis  <= last.axis;
      degen <= last.degen;
      if (last.degen) begin
        qx <= '0; qy <= '0; qz <= '0; qw <= '0;
      end else begin
        case (last.axis)
          AXIS_W: begin
            qx <= c0; qy <= c1; qz <= c2; qw <= bv;
          end
          AXIS_X: begin
            qx <= bv; qy <= c0; qz <= c1; qw <= c2;
          end
          AXIS_Y: begin
            qx <= c0; qy <= bv; qz <= c1; qw <= c2;
          end
          AXIS_Z: begin
            qx <= c0; qy <= c1; qz <= bv; qw <= c2;
          end
          default: begin
            qx <= c0; qy <= c1; qz <= c2; qw <= bv;
          end
        endcase
      end
    end
  end

  assign dst.valid        = ov;
  assign dst.qx           = qx;
  assign dst.qy           = qy;
  assign dst.qz           = qz;
  assign dst.qw           = qw;
  assign dst.largest_axis = axis;
  assign dst.degenerate   = degen;

endmodule

/* rtl/core/rotation_matrix_to_quaternion_top.sv */
// Rotation matrix to quaternion. Takes one 3x3 matrix per transaction and
// returns (qx, qy, qz, qw), the index of the largest component and a
// degenerate flag. The block accepts a new matrix every clock cycle while
// the output is not stalled. Each transaction passes through select stages
// A and B, then S = ceil((max(WORD_BITS, FRAC_BITS) + 2 + FRAC_BITS) / 2)
// square root stages, one root bit per stage, then a division pipeline that
// retires one quotient bit per stage, then an output register. Words default
// to Q2.14. Every stage holds its data under back-pressure, so empty stages
// still fill while the output waits.
module rotation_matrix_to_quaternion_top #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 14
) (
  input logic        clk,
  input logic        rst,
  rmq_mat_if.sink    mat_in,
  rmq_quat_if.source quat_out
);
  import rmq_pkg::*;

  localparam int NW   = WORD_BITS + 1;
  localparam int RADW = ((WORD_BITS + 2 > FRAC_BITS + 2) ? WORD_BITS + 2
                                                        : FRAC_BITS + 2) + 1;
  localparam int SQW  = RADW - 1 + FRAC_BITS;
  localparam int SQB  = (SQW + 1) / 2;

  rmq_work_if #(.NUMW(NW), .MAGW(RADW - 1)) sel_to_sqrt ();
  rmq_work_if #(.NUMW(NW), .MAGW(SQB - 1))  sqrt_to_div ();

  rmq_select #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_select (
    .clk (clk),
    .rst (rst),
    .src (mat_in),
    .dst (sel_to_sqrt)
  );

  rmq_sqrt #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk (clk),
    .rst (rst),
    .src (sel_to_sqrt),
    .dst (sqrt_to_div)
  );

  rmq_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .src (sqrt_to_div),
    .dst (quat_out)
  );

endmodule

/* rtl/core/rmq_checker.sv */
`include "rotation_matrix_to_quaternion_top_assert.svh"

module rmq_checker #(
  parameter int WORD_BITS = 16
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [WORD_BITS-1:0] qx,
  input logic signed [WORD_BITS-1:0] qy,
  input logic signed [WORD_BITS-1:0] qz,
  input logic signed [WORD_BITS-1:0] qw,
  input logic [1:0]                  largest_axis,
  input logic                        degenerate
);
  import rmq_pkg::*;

  logic signed [WORD_BITS-1:0] chosen;

  always_comb begin
    case (axis_t'(largest_axis))
      AXIS_W:  chosen = qw;
      AXIS_X:  chosen = qx;
      AXIS_Y:  chosen = qy;
      AXIS_Z:  chosen = qz;
      default: chosen = qw;
    endcase
  end

  // A degenerate transaction carries an all-zero quaternion.
  `RMQ_ASSERT_NOW(a_degen_zero, clk, rst, out_valid && degenerate, qx == 0 && qy == 0 && qz == 0 && qw == 0)
  // The chosen component is a square root of a positive radicand.
  `RMQ_ASSERT_NOW(a_chosen_pos, clk, rst, out_valid && !degenerate, chosen > 0)
  `RMQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(qx) && $stable(qw) && $stable(largest_axis))
  `RMQ_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid)

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker #(.WORD_BITS(WORD_BITS)) u_rmq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (quat_out.valid),
  .out_ready    (quat_out.ready),
  .qx           (quat_out.qx),
  .qy           (quat_out.qy),
  .qz           (quat_out.qz),
  .qw           (quat_out.qw),
  .largest_axis (quat_out.largest_axis),
  .degenerate   (quat_out.degenerate)
);
